// ===== hw/rtl/edd_pkg.sv =====
// Shared types and constants of the error diffusion dither core.
package edd_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int COL_W = 16;
	localparam int HEIGHT_REG_W = 11;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [COL_W-1:0] IMAGE_WIDTH_RESET = 16'd640;
	localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

	localparam int LUMA_R = 299;
	localparam int LUMA_G = 587;
	localparam int LUMA_B = 114;
	localparam int LUMA_ROUND = 500;
	localparam int SUM_W = 18;
	localparam int RECIP_1000 = 268436;
	localparam int RECIP_W = 19;
	localparam int RECIP_SHIFT = 28;
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam int THRESHOLD = 127;
	localparam int WHITE_LEVEL = 255;

	localparam int QUEUE_DEPTH = 4;

	localparam int SIDE_W = 7;
	localparam int DIAG_W = 6;

	typedef struct packed {
		logic first_col;
		logic top_row;
		logic col_last;
		logic img_last;
	} flags_t;

	typedef struct packed {
		logic [7:0] gray;
		flags_t flags;
	} pix_t;

	typedef struct packed {
		logic [DIAG_W-1:0] diag;
		logic [SIDE_W-1:0] side;
	} line_t;

endpackage

// ===== hw/rtl/edd_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module edd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/edd_front.sv =====
// Front part: configuration registers, pixel intake, position tracking and gray conversion.
module edd_front #(
	parameter int MAX_ROWS = 1024,
	parameter int ROW_W = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [edd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  logic [7:0]                         red,
	input  logic [7:0]                         green,
	input  logic [7:0]                         blue,
	output logic                               push,
	output logic [ROW_W-1:0]                   push_row,
	output edd_pkg::pix_t                      push_pix,
	input  logic                               q_full
);

	localparam int HGT_W = $clog2(MAX_ROWS + 1);
	localparam int SUM_W = edd_pkg::SUM_W;
	localparam int PROD_W = edd_pkg::PROD_W;

	logic [edd_pkg::COL_W-1:0] width_q;
	logic [edd_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [edd_pkg::COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [HGT_W-1:0] h_eff;
	logic [edd_pkg::COL_W-1:0] w_eff;
	logic [HGT_W-1:0] row_next_cnt;
	logic [edd_pkg::COL_W:0] col_next_cnt;
	edd_pkg::flags_t flags;

	logic adv;
	logic accept;
	logic [SUM_W-1:0] sum;
	logic [PROD_W-1:0] prod;

	logic valid_s1;
	logic [SUM_W-1:0] sum_s1;
	edd_pkg::flags_t flags_s1;
	logic [ROW_W-1:0] row_s1;

	logic valid_s2;
	edd_pkg::pix_t pix_s2;
	logic [ROW_W-1:0] row_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= edd_pkg::IMAGE_WIDTH_RESET;
			height_q <= edd_pkg::IMAGE_HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				edd_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_wdata;
				end
				edd_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_wdata[edd_pkg::HEIGHT_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (height_q == '0) begin
			h_eff = HGT_W'(1);
		end else if (32'(height_q) > 32'(MAX_ROWS)) begin
			h_eff = HGT_W'(MAX_ROWS);
		end else begin
			h_eff = HGT_W'(height_q);
		end
	end

	assign w_eff = (width_q == '0) ? edd_pkg::COL_W'(1) : width_q;
	assign row_next_cnt = HGT_W'(row_q) + HGT_W'(1);
	assign col_next_cnt = {1'b0, col_q} + (edd_pkg::COL_W + 1)'(1);

	always_comb begin
		flags.first_col = (col_q == '0);
		flags.top_row = (row_q == '0);
		flags.col_last = (row_next_cnt >= h_eff);
		flags.img_last = flags.col_last && (col_next_cnt >= {1'b0, w_eff});
	end

	assign adv = !(valid_s2 && q_full);
	assign pix_stall = !adv;
	assign accept = pix_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (flags.col_last) begin
				row_q <= '0;
				col_q <= flags.img_last ? '0 : col_next_cnt[edd_pkg::COL_W-1:0];
			end else begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	assign sum = SUM_W'(red) * SUM_W'(edd_pkg::LUMA_R)
		+ SUM_W'(green) * SUM_W'(edd_pkg::LUMA_G)
		+ SUM_W'(blue) * SUM_W'(edd_pkg::LUMA_B)
		+ SUM_W'(edd_pkg::LUMA_ROUND);

	// Division by 1000 as a multiply by a rounded-up reciprocal; exact for every sum here.
	assign prod = PROD_W'(sum_s1) * PROD_W'(edd_pkg::RECIP_1000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (accept) begin
				sum_s1 <= sum;
				flags_s1 <= flags;
				row_s1 <= row_q;
			end
			if (valid_s1) begin
				pix_s2.gray <= prod[edd_pkg::RECIP_SHIFT +: 8];
				pix_s2.flags <= flags_s1;
				row_s2 <= row_s1;
			end
		end
	end

	assign push = valid_s2 && !q_full;
	assign push_row = row_s2;
	assign push_pix = pix_s2;

endmodule

// ===== hw/rtl/edd_queue.sv =====
// Short request queue between the front and back parts.
module edd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + CNT_W'(1);
				end
				2'b01: begin
					count_q <= count_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/edd_back.sv =====
// Back part: line store access, error diffusion, thresholding and result register.
module edd_back #(
	parameter int MAX_ROWS = 1024,
	parameter int ROW_W = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic [ROW_W-1:0]   q_row,
	input  edd_pkg::pix_t      q_pix,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               white,
	output logic [7:0]         level,
	output logic               column_last,
	output logic               image_last
);

	localparam int SIDE_W = edd_pkg::SIDE_W;
	localparam int DIAG_W = edd_pkg::DIAG_W;
	localparam int LINE_W = $bits(edd_pkg::line_t);

	logic adv;

	logic valid_s3;
	logic [ROW_W-1:0] row_s3;
	edd_pkg::pix_t pix_s3;
	logic fwd_s3;
	edd_pkg::line_t fwd_data_s3;

	logic [DIAG_W-1:0] pending_q;
	logic [SIDE_W-1:0] carry_q;

	logic valid_s4;
	logic white_s4;
	logic [7:0] level_s4;
	logic col_last_s4;
	logic img_last_s4;

	logic [LINE_W-1:0] ram_rdata;
	edd_pkg::line_t rd_line;
	edd_pkg::line_t wr_line;
	logic we;

	logic [SIDE_W-1:0] diag_in;
	logic [SIDE_W-1:0] side_in;
	logic [SIDE_W-1:0] down_in;
	logic [7:0] lvl1;
	logic [7:0] lvl2;
	logic [7:0] lvl3;
	logic is_white;
	logic signed [8:0] err;
	logic signed [10:0] err3;
	logic signed [10:0] err3_adj;
	logic signed [8:0] err_adj;
	logic [SIDE_W-1:0] side_share;
	logic [DIAG_W-1:0] diag_share;

	function automatic logic [7:0] add_clamp(input logic [7:0] lvl, input logic [6:0] share);
		logic signed [9:0] s;
		s = $signed({2'b00, lvl}) + $signed({{3{share[6]}}, share});
		if (s < 10'sd0) begin
			return 8'd0;
		end else if (s > 10'sd255) begin
			return 8'd255;
		end else begin
			return s[7:0];
		end
	endfunction

	assign adv = !valid_s4 || !res_stall;
	assign q_pop = adv && !q_empty;
	assign we = adv && valid_s3;

	edd_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_ROWS)
	) u_line_ram (
		.clk(clk),
		.we(we),
		.waddr(row_s3),
		.wdata(wr_line),
		.re(q_pop),
		.raddr(q_row),
		.rdata(ram_rdata)
	);

	// An entry written in the same cycle as it is read comes from the bypass register.
	assign rd_line = fwd_s3 ? fwd_data_s3 : edd_pkg::line_t'(ram_rdata);

	always_comb begin
		diag_in = (pix_s3.flags.first_col || pix_s3.flags.top_row)
			? '0 : {rd_line.diag[DIAG_W-1], rd_line.diag};
		side_in = pix_s3.flags.first_col ? '0 : rd_line.side;
		down_in = pix_s3.flags.top_row ? '0 : carry_q;

		lvl1 = add_clamp(pix_s3.gray, diag_in);
		lvl2 = add_clamp(lvl1, side_in);
		lvl3 = add_clamp(lvl2, down_in);

		is_white = (lvl3 > 8'(edd_pkg::THRESHOLD));
		err = is_white ? ($signed({1'b0, lvl3}) - 9'(edd_pkg::WHITE_LEVEL))
			: $signed({1'b0, lvl3});

		err3 = $signed({{2{err[8]}}, err}) + $signed({err[8], err, 1'b0});
		err3_adj = err3 + (err3[10] ? 11'sd7 : 11'sd0);
		side_share = err3_adj[9:3];

		err_adj = err + (err[8] ? 9'sd3 : 9'sd0);
		diag_share = err_adj[7:2];

		wr_line.diag = pending_q;
		wr_line.side = side_share;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			pending_q <= '0;
			carry_q <= '0;
		end else begin
			if (adv) begin
				valid_s3 <= q_pop;
				valid_s4 <= valid_s3;
			end
			if (we) begin
				pending_q <= pix_s3.flags.col_last ? '0 : diag_share;
				carry_q <= pix_s3.flags.col_last ? '0 : side_share;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			row_s3 <= q_row;
			pix_s3 <= q_pix;
			fwd_s3 <= valid_s3 && (q_row == row_s3);
			fwd_data_s3 <= wr_line;
		end
		if (we) begin
			white_s4 <= is_white;
			level_s4 <= lvl3;
			col_last_s4 <= pix_s3.flags.col_last;
			img_last_s4 <= pix_s3.flags.img_last;
		end
	end

	assign res_valid = valid_s4;
	assign white = white_s4;
	assign level = level_s4;
	assign column_last = col_last_s4;
	assign image_last = img_last_s4;

endmodule

// ===== hw/rtl/error_diffusion_dither_core.sv =====
// Top level of the error diffusion dither core.
// Pixels enter on the pix channel (red, green, blue) in column-major order, top to bottom
// within each column, and each one yields one result on the res channel: white, the
// adjusted gray level, and column_last / image_last markers. A request moves on a channel
// at a clock edge where valid is high and stall is low.
// The image size is set through the write port: index 0 is the width in columns, index 1
// the height in rows, at most MAX_ROWS. Write it only while no pixel is in flight.
// From acceptance, a pixel passes two front stages for the gray conversion, the request
// queue, the line store read, then the result register.
// Without stalls, throughput is one pixel per cycle; the limit is the single read and
// single write port of the line store and the per-pixel clamp and error loop in the
// back stage. When the receiver stalls, the result register and the back stage hold, and
// the queue of four entries absorbs the front until it fills, after which pix_stall rises.
// Reset clears the position counters, the carried error shares and all valid flags, and
// sets the size to 640 by 480. The line store is not cleared; the first column of an image
// never uses what it reads from it.
module error_diffusion_dither_core #(
	parameter int MAX_ROWS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [edd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [edd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic                             white,
	output logic [7:0]                       level,
	output logic                             column_last,
	output logic                             image_last
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int Q_W = ROW_W + $bits(edd_pkg::pix_t);

	logic fq_push;
	logic [ROW_W-1:0] fq_row;
	edd_pkg::pix_t fq_pix;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic [Q_W-1:0] q_rdata;
	logic [ROW_W-1:0] q_row;
	edd_pkg::pix_t q_pix;

	edd_front #(
		.MAX_ROWS(MAX_ROWS),
		.ROW_W(ROW_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.push(fq_push),
		.push_row(fq_row),
		.push_pix(fq_pix),
		.q_full(q_full)
	);

	edd_queue #(
		.WIDTH(Q_W),
		.DEPTH(edd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(fq_push),
		.wdata({fq_row, fq_pix}),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	assign q_row = q_rdata[Q_W-1 -: ROW_W];
	assign q_pix = edd_pkg::pix_t'(q_rdata[$bits(edd_pkg::pix_t)-1:0]);

	edd_back #(
		.MAX_ROWS(MAX_ROWS),
		.ROW_W(ROW_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_row(q_row),
		.q_pix(q_pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.white(white),
		.level(level),
		.column_last(column_last),
		.image_last(image_last)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !fq_push)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_image_end_is_column_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!image_last || column_last))
		else $error("image end marked off a column end");

	a_white_matches_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (white == (level > 8'd127)))
		else $error("white flag disagrees with level");

endmodule

// ===== test/error_diffusion_dither_core_tb.sv =====
// Self-checking testbench of the error diffusion dither core with a built-in pixel predictor.
module error_diffusion_dither_core_tb;

	localparam int DEPTH = 1024;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic       white;
		logic [7:0] level;
		logic       column_last;
		logic       image_last;
	} shade_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [edd_pkg::CFG_INDEX_W-1:0] cfg_index = edd_pkg::REG_IMAGE_WIDTH;
	logic [edd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                            pix_valid = 1'b0;
	logic                            pix_stall;
	logic [7:0]                      red = '0;
	logic [7:0]                      green = '0;
	logic [7:0]                      blue = '0;
	logic                            res_valid;
	logic                            res_stall = 1'b0;
	logic                            white;
	logic [7:0]                      level;
	logic                            column_last;
	logic                            image_last;

	// Predictor state: image size, the two error lines, carried shares and position.
	logic [15:0]       img_width = 16'd640;
	logic [10:0]       img_height = 11'd480;
	logic signed [6:0] side_share [DEPTH];
	logic signed [5:0] diag_share [DEPTH];
	int                held_diag = 0;
	int                down_share = 0;
	logic [15:0]       col_pos = '0;
	int                row_pos = 0;
	int                rows_filled = 0;
	bit                image_done = 1'b0;

	shade_t shades [$];
	bit     steady = 1'b0;
	int     mismatches = 0;
	int     checked = 0;
	int     images = 0;
	int     settings = 0;
	int     cycles = 0;

	error_diffusion_dither_core #(
		.MAX_ROWS(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.white(white),
		.level(level),
		.column_last(column_last),
		.image_last(image_last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("error_diffusion_dither_core: mismatch");
			$finish;
		end
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(0, 99) < 10);
	endfunction

	function automatic int clamp_byte(int v);
		if (v < 0)
			return 0;
		if (v > 255)
			return 255;
		return v;
	endfunction

	function automatic int rows_of(int h);
		if (h == 0)
			return 1;
		if (h > DEPTH)
			return DEPTH;
		return h;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("ERROR at cycle %0d: %0s is %0d, expected %0d", cycles, what, got, want);
	endtask

	task automatic shade_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int w;
		int h;
		int lv;
		int err;
		int diag_in;
		int side_in;
		int down_in;
		bit first_col;
		bit top_row;
		bit col_end;
		bit img_end;
		shade_t s;
		w = (img_width == 0) ? 1 : int'(img_width);
		h = rows_of(int'(img_height));
		first_col = (col_pos == 0);
		top_row = (row_pos == 0);
		col_end = (row_pos + 1 >= h);
		img_end = col_end && (int'(col_pos) + 1 >= w);
		lv = (299 * int'(r) + 587 * int'(g) + 114 * int'(b) + 500) / 1000;
		diag_in = 0;
		side_in = 0;
		down_in = 0;
		if (!first_col && !top_row)
			diag_in = diag_share[row_pos];
		if (!first_col)
			side_in = side_share[row_pos];
		if (!top_row)
			down_in = down_share;
		lv = clamp_byte(lv + diag_in);
		lv = clamp_byte(lv + side_in);
		lv = clamp_byte(lv + down_in);
		s.white = (lv > 127);
		err = s.white ? lv - 255 : lv;
		if (!top_row)
			diag_share[row_pos] = 6'(held_diag);
		side_share[row_pos] = 7'((3 * err) / 8);
		held_diag = col_end ? 0 : (2 * err) / 8;
		down_share = col_end ? 0 : (3 * err) / 8;
		if (row_pos + 1 > rows_filled)
			rows_filled = row_pos + 1;
		if (col_end) begin
			row_pos = 0;
			col_pos = img_end ? 16'd0 : col_pos + 16'd1;
		end else begin
			row_pos++;
		end
		if (img_end)
			images++;
		image_done = img_end;
		s.level = lv[7:0];
		s.column_last = col_end;
		s.image_last = img_end;
		shades.push_back(s);
	endtask

	task automatic check_shade();
		shade_t want;
		if (shades.size() == 0) begin
			note_mismatch("result with nothing pending, level", int'(level), 0);
		end else begin
			want = shades.pop_front();
			checked++;
			if (white !== want.white)
				note_mismatch("white", int'(white), int'(want.white));
			if (level !== want.level)
				note_mismatch("level", int'(level), int'(want.level));
			if (column_last !== want.column_last)
				note_mismatch("column_last", int'(column_last), int'(want.column_last));
			if (image_last !== want.image_last)
				note_mismatch("image_last", int'(image_last), int'(want.image_last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_shade();
			res_stall <= take_break();
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while (take_break()) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (pix_stall);
		shade_pixel(r, g, b);
	endtask

	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_pixel();
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0) begin
			r = 8'($urandom_range(120, 135));
			g = r;
			b = r;
		end else begin
			r = random_channel();
			g = random_channel();
			b = random_channel();
		end
		send_pixel(r, g, b);
	endtask

	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (shades.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_size(input int w, input int h);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= edd_pkg::REG_IMAGE_WIDTH;
		cfg_wdata <= w[15:0];
		@(posedge clk);
		cfg_index <= edd_pkg::REG_IMAGE_HEIGHT;
		cfg_wdata <= {5'd0, h[10:0]};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		img_width = w[15:0];
		img_height = h[10:0];
		settings++;
	endtask

	task automatic test_reset_size();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		// The column is already past the new bottom row, so the next pixel closes it.
		set_size(640, 3);
		send_pixel(8'd200, 8'd10, 8'd60);
		send_pixel(8'd90, 8'd140, 8'd30);
		set_size(2, 3);
		send_pixel(8'd127, 8'd127, 8'd127);
		send_pixel(8'd128, 8'd127, 8'd128);
	endtask

	task automatic test_zero_size();
		set_size(0, 0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd127, 8'd127, 8'd127);
		send_pixel(8'd1, 8'd2, 8'd3);
	endtask

	task automatic test_diffusion();
		set_size(3, 4);
		for (int i = 0; i < 12; i++) begin
			case (i % 3)
				0: send_pixel(8'd255, 8'd255, 8'd255);
				1: send_pixel(8'd0, 8'd0, 8'd0);
				default: send_pixel(8'd128, 8'd128, 8'd128);
			endcase
		end
	endtask

	task automatic test_tall_column();
		set_size(1, 2047);
		repeat (200) send_random_pixel();
		// Shrinking the height below the current row closes the column on the next pixel.
		set_size(1, 2);
		send_random_pixel();
	endtask

	task automatic test_wide_image();
		set_size(65535, 2);
		repeat (6) send_random_pixel();
		set_size(1, 2);
		repeat (2) send_random_pixel();
	endtask

	task automatic test_random(input int count);
		int sent;
		int phase;
		int w;
		int h;
		int run;
		sent = 0;
		phase = 0;
		while (sent < count) begin
			phase++;
			steady = (sent >= 250 && sent < 450);
			case ($urandom_range(0, 19))
				0: w = 0;
				1: w = 65535;
				2: w = $urandom_range(0, 65535);
				default: w = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 19))
				0: h = 0;
				1: h = $urandom_range(1025, 2047);
				2: h = $urandom_range(13, 64);
				default: h = $urandom_range(1, 12);
			endcase
			// Growing the height mid-image must not reach line entries never written.
			if (col_pos != 0 && rows_of(h) > rows_filled)
				h = rows_filled;
			set_size(w, h);
			if (phase == 3) begin
				repeat (3) send_random_pixel();
				sent += 3;
				wait_idle();
			end
			if ($urandom_range(0, 4) == 0) begin
				run = $urandom_range(1, 20);
				repeat (run) send_random_pixel();
				sent += run;
			end else begin
				run = 0;
				do begin
					send_random_pixel();
					run++;
				end while (!image_done && run < 150);
				sent += run;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_zero_size();
		test_diffusion();
		test_tall_column();
		test_wide_image();
		test_random(420);
		wait_idle();
		if (shades.size() != 0)
			note_mismatch("results still missing", 0, shades.size());
		$display("Checked %0d pixels in %0d finished images under %0d size settings,",
			checked, images, settings);
		$display("including zero sizes, a height above the line depth and 65535 columns.");
		if (mismatches == 0) begin
			$display("error_diffusion_dither_core: match");
		end else begin
			$display("error_diffusion_dither_core: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/edd_pkg.sv
hw/rtl/edd_ram.sv
hw/rtl/edd_front.sv
hw/rtl/edd_queue.sv
hw/rtl/edd_back.sv
hw/rtl/error_diffusion_dither_core.sv
test/error_diffusion_dither_core_tb.sv
